/* rtl/rbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_pkg
// Types and constants shared by the RBSP bit reader modules.
// ----------------------------------------------------------------------------
package rbr_pkg;

	localparam int FUNC_W    = 3;
	localparam int BYTE_W    = 8;
	localparam int CNT_W     = 15;
	localparam int VAL_W     = 32;
	localparam int BITS_W    = 16;
	localparam int POS_W     = 13;
	localparam int LZ_W      = 5;
	localparam int MAX_FIXED = 32;
	localparam int EMU_BYTE  = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_START = 3'd0,
		FN_LOAD  = 3'd1,
		FN_READ  = 3'd2,
		FN_UE    = 3'd3,
		FN_SKIP  = 3'd4
	} func_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] load_byte;
		logic [CNT_W-1:0]  bit_count;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic              failed;
		logic [BITS_W-1:0] bits_consumed;
		logic [POS_W-1:0]  byte_position;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RUN,
		ST_PFX_CHK,
		ST_PFX_RUN,
		ST_PFX_EVAL,
		ST_SFX_RUN,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic load;
		logic set_err;
		logic cnt_count;
		logic cnt_one;
		logic cnt_lz;
		logic lz_clr;
		logic lz_inc;
		logic fetch;
		logic step;
		logic sum;
		logic acc_clr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              err;
		logic              cnt_zero;
		logic              cur_vld;
		logic              acc_bit0;
		logic              lz_max;
		logic              cnt_gt_max;
		logic              skip_too_long;
	} sts_t;

endpackage

/* rtl/rbsp_bit_reader_exp_golomb_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsp_bit_reader_exp_golomb_core
// RBSP bit reader with emulation prevention removal and ue(v) decoding.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives one result.
// A fixed read or skip takes its bits one at a time, and each new store byte,
// a dropped 0x03 byte included, is first fetched through the single
// registered read port of the byte store. A ue code reads its prefix one bit
// per request of the bit engine, then its suffix. A new request is taken
// while an earlier result still waits in the output register.
// ----------------------------------------------------------------------------
module rbsp_bit_reader_exp_golomb_core
	import rbr_pkg::*;
#(
	parameter int BUF_BYTES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	rbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rbr_dpath #(
		.BUF_BYTES (BUF_BYTES)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

/* rtl/rbr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_ctrl
// Sequencer for the bit reader: decodes each request and steps the datapath
// one bit at a time through fixed reads, ue codes and skips.
// ----------------------------------------------------------------------------
module rbr_ctrl
	import rbr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_vld_q;
	logic   run_exit;

	assign run_exit  = sts.err | sts.cnt_zero;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_vld_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.func)
					FN_READ: state_nxt = sts.cnt_gt_max ? ST_DONE : ST_RUN;
					FN_UE:   state_nxt = ST_PFX_CHK;
					FN_SKIP: state_nxt = sts.skip_too_long ? ST_DONE : ST_RUN;
					default: state_nxt = ST_DONE;
				endcase
			end
			ST_RUN: begin
				if (run_exit) begin
					state_nxt = ST_DONE;
				end
			end
			ST_PFX_CHK: begin
				state_nxt = sts.err ? ST_SFX_RUN : ST_PFX_RUN;
			end
			ST_PFX_RUN: begin
				if (run_exit) begin
					state_nxt = ST_PFX_EVAL;
				end
			end
			ST_PFX_EVAL: begin
				if (sts.acc_bit0) begin
					state_nxt = ST_SFX_RUN;
				end else if (sts.lz_max) begin
					state_nxt = ST_DONE;
				end else begin
					state_nxt = ST_PFX_CHK;
				end
			end
			ST_SFX_RUN: begin
				if (run_exit) begin
					state_nxt = ST_SUM;
				end
			end
			ST_SUM: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_vld_q || !rsp_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = req_valid;
			end
			ST_DISPATCH: begin
				case (sts.func)
					FN_START: cmd.clear = 1'b1;
					FN_LOAD:  cmd.load  = 1'b1;
					FN_READ: begin
						cmd.set_err   = sts.cnt_gt_max;
						cmd.cnt_count = ~sts.cnt_gt_max;
					end
					FN_UE:    cmd.lz_clr = 1'b1;
					FN_SKIP: begin
						cmd.set_err   = sts.skip_too_long;
						cmd.cnt_count = ~sts.skip_too_long;
					end
					default: cmd = '0;
				endcase
			end
			ST_RUN, ST_PFX_RUN, ST_SFX_RUN: begin
				cmd.fetch = ~run_exit & ~sts.cur_vld;
				cmd.step  = ~run_exit & sts.cur_vld;
			end
			ST_PFX_CHK: begin
				cmd.cnt_lz  = sts.err;
				cmd.cnt_one = ~sts.err;
			end
			ST_PFX_EVAL: begin
				if (sts.acc_bit0) begin
					cmd.cnt_lz = 1'b1;
				end else if (sts.lz_max) begin
					cmd.set_err = 1'b1;
					cmd.acc_clr = 1'b1;
				end else begin
					cmd.lz_inc = 1'b1;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = ~out_vld_q | ~rsp_stall;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_step_needs_byte : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (sts.cur_vld && !sts.err && !sts.cnt_zero))
		else $error("bit step without a cached byte or with nothing left to read");

	a_accept_dispatch : assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_DISPATCH))
		else $error("accepted request not dispatched");

	a_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || !rsp_stall))
		else $error("pending result overwritten");

	a_done_releases : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (rsp_valid && state_q == ST_IDLE))
		else $error("result load did not return to idle with valid result");

endmodule

/* rtl/rbr_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_dpath
// Byte store, read position, emulation prevention tracking, bit accumulator
// and result register of the bit reader.
// ----------------------------------------------------------------------------
module rbr_dpath
	import rbr_pkg::*;
#(
	parameter int BUF_BYTES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);

	localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
	localparam int LW = $clog2(BUF_BYTES + 1);
	localparam int SW = (LW + 3 > CNT_W) ? LW + 3 : CNT_W;
	localparam logic [LW-1:0] BUF_LEN = LW'(BUF_BYTES);

	logic [BYTE_W-1:0] store_q [BUF_BYTES];

	logic [FUNC_W-1:0] func_q;
	logic [BYTE_W-1:0] byte_q;
	logic [CNT_W-1:0]  count_q;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     idx_q;
	logic [2:0]        off_q;
	logic [1:0]        zr_q;
	logic              err_q;
	logic [BITS_W-1:0] bits_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  acc_q;
	logic [LZ_W-1:0]   lz_q;
	logic [BYTE_W-1:0] cur_q;
	logic              cur_vld_q;
	logic              emu_q;
	rsp_t              rsp_q;

	logic              in_range;
	logic              emu_hit;
	logic              emu_bad;
	logic              cur_bit;
	logic [LW-1:0]     rem_bytes;
	logic [1:0]        zr_nxt;
	logic [VAL_W-1:0]  ue_mask;

	assign in_range  = (idx_q < len_q);
	assign emu_hit   = ~emu_q && (off_q == 3'd0) && (zr_q >= 2'd2) && in_range
		&& (cur_q == BYTE_W'(EMU_BYTE));
	assign emu_bad   = emu_q && (!in_range || (cur_q > BYTE_W'(EMU_BYTE)));
	assign cur_bit   = cur_q[3'd7 - off_q];
	assign rem_bytes = len_q - idx_q;
	assign zr_nxt    = (cur_q != '0) ? 2'd0 : ((zr_q == 2'd3) ? 2'd3 : zr_q + 2'd1);
	assign ue_mask   = (VAL_W'(1) << lz_q) - VAL_W'(1);

	assign sts.func          = func_q;
	assign sts.err           = err_q;
	assign sts.cnt_zero      = (cnt_q == '0);
	assign sts.cur_vld       = cur_vld_q;
	assign sts.acc_bit0      = acc_q[0];
	assign sts.lz_max        = (lz_q == LZ_W'(MAX_FIXED - 1));
	assign sts.cnt_gt_max    = (count_q > CNT_W'(MAX_FIXED));
	assign sts.skip_too_long = (SW'(count_q) > SW'({rem_bytes, 3'b000}));

	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load && (len_q < BUF_LEN)) begin
			store_q[len_q[AW-1:0]] <= byte_q;
		end
		if (cmd.fetch) begin
			cur_q <= store_q[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= req.func;
			byte_q  <= req.load_byte;
			count_q <= req.bit_count;
		end
		if (cmd.out_load) begin
			rsp_q.value         <= ((func_q == FN_READ) || (func_q == FN_UE)) ? acc_q : '0;
			rsp_q.failed        <= err_q;
			rsp_q.bits_consumed <= bits_q;
			rsp_q.byte_position <= POS_W'(idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			idx_q     <= '0;
			off_q     <= '0;
			zr_q      <= '0;
			err_q     <= 1'b0;
			bits_q    <= '0;
			cnt_q     <= '0;
			acc_q     <= '0;
			lz_q      <= '0;
			cur_vld_q <= 1'b0;
			emu_q     <= 1'b0;
		end else begin
			if (cmd.capture || cmd.acc_clr) begin
				acc_q <= '0;
			end
			if (cmd.clear) begin
				len_q     <= '0;
				idx_q     <= '0;
				off_q     <= '0;
				zr_q      <= '0;
				err_q     <= 1'b0;
				bits_q    <= '0;
				cur_vld_q <= 1'b0;
				emu_q     <= 1'b0;
			end
			if (cmd.load) begin
				if (len_q < BUF_LEN) begin
					len_q <= len_q + LW'(1);
				end else begin
					err_q <= 1'b1;
				end
			end
			if (cmd.set_err) begin
				err_q <= 1'b1;
			end
			if (cmd.cnt_count) begin
				cnt_q <= count_q;
			end
			if (cmd.cnt_one) begin
				cnt_q <= CNT_W'(1);
				acc_q <= '0;
			end
			if (cmd.cnt_lz) begin
				cnt_q <= CNT_W'(lz_q);
				acc_q <= '0;
			end
			if (cmd.lz_clr) begin
				lz_q <= '0;
			end
			if (cmd.lz_inc) begin
				lz_q <= lz_q + LZ_W'(1);
			end
			if (cmd.fetch) begin
				cur_vld_q <= 1'b1;
			end
			if (cmd.sum) begin
				acc_q <= acc_q + ue_mask;
			end
			if (cmd.step) begin
				if (emu_hit) begin
					idx_q     <= idx_q + LW'(1);
					zr_q      <= 2'd0;
					cur_vld_q <= 1'b0;
					emu_q     <= 1'b1;
				end else begin
					emu_q <= 1'b0;
					if (emu_bad || !in_range) begin
						err_q <= 1'b1;
					end
					if (in_range) begin
						acc_q  <= {acc_q[VAL_W-2:0], cur_bit};
						bits_q <= bits_q + BITS_W'(1);
						cnt_q  <= cnt_q - CNT_W'(1);
						if (off_q == 3'd7) begin
							zr_q      <= zr_nxt;
							idx_q     <= idx_q + LW'(1);
							off_q     <= 3'd0;
							cur_vld_q <= 1'b0;
						end else begin
							off_q <= off_q + 3'd1;
						end
					end
				end
			end
		end
	end

	a_idx_within_len : assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= len_q)
		else $error("read position beyond loaded data");

	a_bit_counts : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !emu_hit && in_range) |=> (bits_q == $past(bits_q) + BITS_W'(1)))
		else $error("taken bit not counted");

	a_drop_then_fetch : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && emu_hit) |=> (emu_q && !cur_vld_q && off_q == 3'd0))
		else $error("dropped emulation byte not followed by a fresh fetch");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RBSP bit reader with ue(v) decoding.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the error paths and field
// extremes. One unit then fills the byte store to capacity and overflows it.
// Random units of loads, fixed reads, ue reads and skips follow, with zero
// and 0x03 bytes favoured so that emulation prevention is exercised, plus
// some units of pure noise. Every result is checked against its table row or a
// behavioural predictor of the reader state, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
	import rbr_pkg::*;

	localparam int BUF_BYTES   = 256;
	localparam int ITEMS       = 1000;
	localparam int HOLD_CYCLES = 300;
	localparam int BYTE_TOP    = 255;
	localparam int CNT_TOP     = 32767;
	localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

	typedef struct packed {
		req_t r;
		logic typed;
		rsp_t want;
	} row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [7:0]  store_mem [BUF_BYTES];
	int unsigned stored, rd_pos, bit_pos, zeros_seen, bits_read;
	bit          sticky_fail;

	rsp_t        pending [$];
	row_t        dir_rows [$];
	rsp_t        due;
	bit          calm, hold_rx, offering;
	int unsigned n_sent, n_checked, n_bad, n_dropped, n_fail_items;

	rbsp_bit_reader_exp_golomb_core #(
		.BUF_BYTES(BUF_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #6 clk = ~clk;

	function automatic logic [31:0] fetch_bits(int unsigned n);
		logic [31:0] acc;
		logic [7:0]  cur;
		acc = '0;
		if (n > MAX_FIXED) begin
			sticky_fail = 1'b1;
			return '0;
		end
		while (n > 0 && !sticky_fail) begin
			n--;
			if (bit_pos == 0 && zeros_seen >= 2 && rd_pos < stored &&
			    store_mem[rd_pos] == EMU_BYTE) begin
				rd_pos++;
				zeros_seen = 0;
				n_dropped++;
				if (rd_pos >= stored || store_mem[rd_pos] > EMU_BYTE)
					sticky_fail = 1'b1;
			end
			if (rd_pos >= stored) begin
				sticky_fail = 1'b1;
				break;
			end
			cur = store_mem[rd_pos];
			acc = {acc[30:0], cur[7 - bit_pos]};
			bits_read = (bits_read + 1) & 16'hFFFF;
			bit_pos++;
			if (bit_pos == 8) begin
				zeros_seen = (cur != 0) ? 0 : (zeros_seen < 3 ? zeros_seen + 1 : 3);
				rd_pos++;
				bit_pos = 0;
			end
		end
		return acc;
	endfunction

	function automatic logic [31:0] decode_ue();
		int unsigned lead;
		logic [31:0] tail;
		lead = 0;
		while (!sticky_fail && fetch_bits(1) == 0) begin
			lead++;
			if (lead == MAX_FIXED) begin
				sticky_fail = 1'b1;
				return '0;
			end
		end
		tail = fetch_bits(lead);
		return ((32'd1 << lead) - 32'd1) + tail;
	endfunction

	function automatic void skip_ahead(int unsigned cnt);
		int unsigned room, chunk;
		room = (stored - rd_pos) * 8;
		if (cnt > room) begin
			sticky_fail = 1'b1;
			return;
		end
		while (cnt > 0 && !sticky_fail) begin
			chunk = (cnt > MAX_FIXED) ? MAX_FIXED : cnt;
			void'(fetch_bits(chunk));
			cnt -= chunk;
		end
	endfunction

	function automatic rsp_t forecast(req_t r);
		rsp_t        o;
		logic [31:0] v;
		v = '0;
		case (r.func)
			FN_START: begin
				stored      = 0;
				rd_pos      = 0;
				bit_pos     = 0;
				zeros_seen  = 0;
				sticky_fail = 1'b0;
				bits_read   = 0;
			end
			FN_LOAD: begin
				if (stored < BUF_BYTES) begin
					store_mem[stored] = r.load_byte;
					stored++;
				end else begin
					sticky_fail = 1'b1;
				end
			end
			FN_READ: v = fetch_bits(r.bit_count);
			FN_UE:   v = decode_ue();
			FN_SKIP: skip_ahead(r.bit_count);
			default: ;
		endcase
		if (sticky_fail)
			n_fail_items++;
		o.value         = v;
		o.failed        = sticky_fail;
		o.bits_consumed = BITS_W'(bits_read);
		o.byte_position = POS_W'(rd_pos);
		return o;
	endfunction

	function automatic req_t mk(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
		logic [CNT_W-1:0] c);
		req_t r;
		r.func      = f;
		r.load_byte = b;
		r.bit_count = c;
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(0, BYTE_TOP));
	endfunction

	function automatic logic [CNT_W-1:0] rand_cnt();
		return CNT_W'($urandom_range(0, CNT_TOP));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 30)
			return '0;
		if (p < 40)
			return BYTE_W'(EMU_BYTE);
		if (p < 46)
			return BYTE_W'($urandom_range(1, 2));
		return rand_byte();
	endfunction

	function automatic logic [CNT_W-1:0] pick_width();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return CNT_W'($urandom_range(0, MAX_FIXED));
		if (p < 90)
			return CNT_W'($urandom_range(MAX_FIXED + 1, 40));
		return rand_cnt();
	endfunction

	function automatic logic [CNT_W-1:0] pick_skip(int unsigned room);
		int unsigned p, c;
		p = $urandom_range(0, 99);
		if (p < 75)
			return CNT_W'($urandom_range(0, room));
		if (p < 90) begin
			c = room + $urandom_range(1, 16);
			return CNT_W'((c > CNT_TOP) ? CNT_TOP : c);
		end
		return rand_cnt();
	endfunction

	function automatic int unsigned idle_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_row(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
		logic [CNT_W-1:0] c, bit typed = 1'b0, logic [VAL_W-1:0] v = '0,
		logic fl = 1'b0, logic [BITS_W-1:0] nb = '0, logic [POS_W-1:0] ps = '0);
		row_t row;
		row.r                  = mk(f, b, c);
		row.typed              = typed;
		row.want.value         = v;
		row.want.failed        = fl;
		row.want.bits_consumed = nb;
		row.want.byte_position = ps;
		dir_rows.push_back(row);
	endfunction

	task automatic send(input req_t r, input bit typed = 1'b0, input rsp_t want = '0);
		int unsigned gap;
		rsp_t guess;
		req       <= r;
		req_valid <= 1'b1;
		offering = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		guess = forecast(r);
		pending.push_back(typed ? want : guess);
		n_sent++;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (offering) begin
			req_valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic run_unit();
		int unsigned nbytes, nops, sel, room;
		nbytes = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 80);
		nops   = $urandom_range(2, 14);
		send(mk(FN_START, rand_byte(), rand_cnt()));
		repeat (nbytes) send(mk(FN_LOAD, pick_byte(), rand_cnt()));
		repeat (nops) begin
			sel  = $urandom_range(0, 99);
			room = (stored - rd_pos) * 8;
			if (sel < 40)
				send(mk(FN_READ, rand_byte(), pick_width()));
			else if (sel < 65)
				send(mk(FN_UE, rand_byte(), rand_cnt()));
			else if (sel < 80)
				send(mk(FN_SKIP, rand_byte(), pick_skip(room)));
			else if (sel < 90)
				send(mk(FN_LOAD, pick_byte(), rand_cnt()));
			else if (sel < 96)
				send(mk(FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), rand_byte(),
					rand_cnt()));
			else
				send(mk(FN_START, rand_byte(), rand_cnt()));
		end
	endtask

	task automatic noise_unit();
		repeat ($urandom_range(3, 12))
			send(mk(FUNC_W'($urandom_range(0, 7)), rand_byte(), rand_cnt()));
	endtask

	// response side: random stalls, calm stretches and one long hold on request
	initial begin
		int unsigned n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				hold_rx = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (calm) begin
				rsp_stall <= 1'b0;
			end else begin
				n = idle_len();
				if (n == 0) begin
					rsp_stall <= 1'b0;
				end else begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: value %h failed %b bits %0d pos %0d",
						rsp.value, rsp.failed, rsp.bits_consumed, rsp.byte_position);
			end else begin
				due = pending.pop_front();
				n_checked++;
				if (rsp.value !== due.value || rsp.failed !== due.failed ||
				    rsp.bits_consumed !== due.bits_consumed ||
				    rsp.byte_position !== due.byte_position) begin
					n_bad++;
					if (n_bad <= 10)
						$display("result %0d: want %h/%b/%0d/%0d got %h/%b/%0d/%0d",
							n_checked, due.value, due.failed, due.bits_consumed,
							due.byte_position, rsp.value, rsp.failed,
							rsp.bits_consumed, rsp.byte_position);
				end
			end
		end
	end

	initial begin
		#(100_000_000);
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned mark, unit;
		calm     = 1'b0;
		hold_rx  = 1'b0;
		offering = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(FN_START, 8'h00, '0, 1'b1);
		add_row(FN_READ, 8'h00, '0, 1'b1);
		add_row(FN_SKIP, 8'hFF, CNT_W'(CNT_TOP), 1'b1, '0, 1'b1);
		add_row(FN_SPARE_LO, 8'hFF, CNT_W'(CNT_TOP), 1'b1, '0, 1'b1);
		add_row(FN_UE, 8'h00, '0, 1'b1, '0, 1'b1);
		add_row(FN_START, 8'hFF, CNT_W'(CNT_TOP), 1'b1);
		add_row(FN_READ, 8'h00, CNT_W'(MAX_FIXED + 1), 1'b1, '0, 1'b1);
		add_row(FN_SPARE_MID, 8'h00, '0, 1'b1, '0, 1'b1);
		add_row(FN_START, 8'h00, '0, 1'b1);
		repeat (4) add_row(FN_LOAD, 8'h00, '0, 1'b1);
		add_row(FN_UE, 8'h00, '0, 1'b1, '0, 1'b1, 16'd32, 13'd4);
		add_row(FN_START, 8'h00, '0, 1'b1);
		add_row(FN_LOAD, 8'hFF, '0, 1'b1);
		add_row(FN_LOAD, 8'h00, '0, 1'b1);
		add_row(FN_LOAD, 8'h00, '0, 1'b1);
		add_row(FN_LOAD, BYTE_W'(EMU_BYTE), '0, 1'b1);
		add_row(FN_LOAD, 8'h04, '0, 1'b1);
		add_row(FN_READ, 8'h00, CNT_W'(MAX_FIXED));
		add_row(FN_SPARE_HI, 8'hFF, CNT_W'(CNT_TOP));
		add_row(FN_START, 8'h00, '0, 1'b1);
		foreach (dir_rows[i])
			send(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// fill the store to capacity, skip through it, then overflow it
		send(mk(FN_START, rand_byte(), rand_cnt()));
		repeat (BUF_BYTES) send(mk(FN_LOAD, rand_byte(), rand_cnt()));
		send(mk(FN_SKIP, rand_byte(), CNT_W'(BUF_BYTES * 8 - 1)));
		send(mk(FN_READ, rand_byte(), CNT_W'(MAX_FIXED)));
		send(mk(FN_UE, rand_byte(), rand_cnt()));
		send(mk(FN_LOAD, 8'hFF, rand_cnt()));
		send(mk(FN_START, rand_byte(), rand_cnt()));
		drain();

		mark = n_sent;
		unit = 0;
		while (n_sent - mark < ITEMS) begin
			calm = (unit % 9 == 4);
			if (unit % 25 == 3) begin
				calm    = 1'b1;
				hold_rx = 1'b1;
				run_unit();
			end else if ($urandom_range(0, 99) < 12) begin
				noise_unit();
			end else begin
				run_unit();
			end
			if (unit % 10 == 9)
				drain();
			unit++;
		end
		calm = 1'b0;
		drain();
		repeat (40) @(posedge clk);

		$display("run covered %0d requests and %0d checked results", n_sent, n_checked);
		$display("%0d 0x03 bytes removed, %0d results flagged failed, %0d mismatches",
			n_dropped, n_fail_items, n_bad);
		if (n_bad == 0 && pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
